### rtl/iir_dec_pkg.sv
// Shared widths, types and constants for the IIR filter decimator.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package iir_dec_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 20;
    localparam int COEF_FRAC   = COEF_W - 4;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = PROD_W + 3;
    localparam int NUM_FF_TAPS = 3;
    localparam int DECIM_W     = 16;
    localparam int GROUP_W     = 13;
    localparam int POS_W       = 12;
    localparam int GROUP_MAX   = 4096;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Register map; the byte address is four times the index.
    typedef enum logic [2:0] {
        REG_B0    = 3'd0,
        REG_B1    = 3'd1,
        REG_B2    = 3'd2,
        REG_A1    = 3'd3,
        REG_A2    = 3'd4,
        REG_DECIM = 3'd5,
        REG_GROUP = 3'd6
    } reg_idx_t;

    // Per-cell strobes: shift the sample line, load the product register.
    typedef struct packed {
        logic shift;
        logic load;
    } tap_ctrl_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam acc_t    ROUND_HALF = acc_t'(1) <<< (COEF_FRAC - 1);

endpackage

`default_nettype wire

### rtl/iir_dec_tap_cell.sv
// One feedforward tap cell: a stage of the input delay line and its product.
// Depends on iir_dec_pkg.
`default_nettype none

module iir_dec_tap_cell
    import iir_dec_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tap_ctrl_t ctrl,
    input  wire sample_t   sample_prev,
    input  wire coef_t     coef,
    output sample_t        sample,
    output prod_t          prod
);

    sample_t sample_reg;
    prod_t   prod_reg;

    // advance the delay line on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            sample_reg <= sample_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= sample_reg * coef;
        end
    end

    assign sample = sample_reg;
    assign prod   = prod_reg;

endmodule

`default_nettype wire

### rtl/iir_dec_fb_loop.sv
// Feedback section: output history, a1/a2 terms, rounding shift and saturation.
// Depends on iir_dec_pkg.
`default_nettype none

module iir_dec_fb_loop
    import iir_dec_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire acc_t    ff_sum,
    input  wire coef_t   coef_a1,
    input  wire coef_t   coef_a2,
    output sample_t      y
);

    sample_t y1_reg;
    sample_t y2_reg;
    prod_t   a2_term_reg;
    prod_t   a2_term_next;
    sample_t a2_operand;
    prod_t   a1_term;
    acc_t    acc;
    acc_t    shifted;

    assign a1_term = y1_reg * coef_a1;
    assign acc     = ff_sum - acc_t'(a1_term) - acc_t'(a2_term_reg);
    assign shifted = acc >>> COEF_FRAC;

    always_comb
    begin
        if (shifted > acc_t'(SAMPLE_MAX))
        begin
            y = SAMPLE_MAX;
        end
        else if (shifted < acc_t'(SAMPLE_MIN))
        begin
            y = SAMPLE_MIN;
        end
        else
        begin
            y = shifted[SAMPLE_W-1:0];
        end
    end

    // the a2 term always tracks a2 times the sample that will be y[n-2]
    assign a2_operand   = step ? y1_reg : y2_reg;
    assign a2_term_next = a2_operand * coef_a2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg      <= '0;
            y2_reg      <= '0;
            a2_term_reg <= '0;
        end
        else
        begin
            a2_term_reg <= a2_term_next;
            if (step)
            begin
                y1_reg <= y;
                y2_reg <= y1_reg;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/iir_filter_decimator.sv
// Second-order direct-form-I IIR filter with decimation and chunk marking.
// Path: an input transfer fills the delay line, then the product, feedforward sum and output registers.
// Throughput: one sample per cycle if the output is free; a1 multiply, sum, saturate are combinational.
// Reset: clears sample and output history, decimation and chunk counters, and
// loads the default coefficients (unity b0, all others zero), factor 1, group 1024.
// Depends on iir_dec_pkg, iir_dec_tap_cell and iir_dec_fb_loop.
`default_nettype none

module iir_filter_decimator
    import iir_dec_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input sample channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire sample_t     sample_in,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output sample_t          sample_out,
    output logic             chunk_end,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam coef_t               B0_RESET    = coef_t'(65536);
    localparam logic [GROUP_W-1:0]  GROUP_RESET = GROUP_W'(1024);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    coef_t              coef_b0_reg;
    coef_t              coef_b1_reg;
    coef_t              coef_b2_reg;
    coef_t              coef_a1_reg;
    coef_t              coef_a2_reg;
    logic [DECIM_W-1:0] decim_factor_reg;
    logic [GROUP_W-1:0] group_length_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // byte address 4*i; the two low address bits are not decoded
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg      <= B0_RESET;
            coef_b1_reg      <= '0;
            coef_b2_reg      <= '0;
            coef_a1_reg      <= '0;
            coef_a2_reg      <= '0;
            decim_factor_reg <= DECIM_W'(1);
            group_length_reg <= GROUP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_B0:    coef_b0_reg      <= pwdata[COEF_W-1:0];
                REG_B1:    coef_b1_reg      <= pwdata[COEF_W-1:0];
                REG_B2:    coef_b2_reg      <= pwdata[COEF_W-1:0];
                REG_A1:    coef_a1_reg      <= pwdata[COEF_W-1:0];
                REG_A2:    coef_a2_reg      <= pwdata[COEF_W-1:0];
                REG_DECIM: decim_factor_reg <= pwdata[DECIM_W-1:0];
                REG_GROUP: group_length_reg <= pwdata[GROUP_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_B0:    prdata = 32'(unsigned'(coef_b0_reg));
            REG_B1:    prdata = 32'(unsigned'(coef_b1_reg));
            REG_B2:    prdata = 32'(unsigned'(coef_b2_reg));
            REG_A1:    prdata = 32'(unsigned'(coef_a1_reg));
            REG_A2:    prdata = 32'(unsigned'(coef_a2_reg));
            REG_DECIM: prdata = 32'(decim_factor_reg);
            REG_GROUP: prdata = 32'(group_length_reg);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    //   A: sample delay line (tap cells), B: tap products, C: feedforward
    //   sum, then the feedback loop writes the output register.
    // Each stage moves on when the stage after it is empty or moving, so
    // bubbles collapse and the block keeps taking samples while a result
    // waits in the output register, until stages A to C are full.
    // ------------------------------------------------------------------
    logic va_reg, va_next;
    logic vb_reg, vb_next;
    logic vc_reg, vc_next;
    logic [DECIM_W-1:0] decim_count_reg, decim_count_next;
    logic out_valid_reg, out_valid_next;
    logic in_xfer;
    logic out_xfer;
    logic out_free;
    logic keep;
    logic d_go, c_go, b_go;

    assign keep     = (decim_count_reg == '0);
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    // a dropped sample needs no room at the output
    assign d_go     = vc_reg && (!keep || out_free);
    assign c_go     = vb_reg && (!vc_reg || d_go);
    assign b_go     = va_reg && (!vb_reg || c_go);
    assign in_stall = va_reg && !b_go;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        va_next = in_xfer ? 1'b1 : (b_go ? 1'b0 : va_reg);
        vb_next = b_go    ? 1'b1 : (c_go ? 1'b0 : vb_reg);
        vc_next = c_go    ? 1'b1 : (d_go ? 1'b0 : vc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    // ------------------------------------------------------------------
    // Feedforward chain: each cell holds one input history sample, hands it
    // to its neighbor on every transfer and forms its own product.
    // ------------------------------------------------------------------
    sample_t   tap_sample [NUM_FF_TAPS+1];
    coef_t     tap_coef   [NUM_FF_TAPS];
    prod_t     tap_prod   [NUM_FF_TAPS];
    tap_ctrl_t tap_ctrl;

    assign tap_sample[0] = sample_in;
    assign tap_coef[0]   = coef_b0_reg;
    assign tap_coef[1]   = coef_b1_reg;
    assign tap_coef[2]   = coef_b2_reg;
    assign tap_ctrl.shift = in_xfer;
    assign tap_ctrl.load  = b_go;

    for (genvar k = 0; k < NUM_FF_TAPS; k++)
    begin : g_tap
        iir_dec_tap_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (tap_ctrl),
            .sample_prev (tap_sample[k]),
            .coef        (tap_coef[k]),
            .sample      (tap_sample[k+1]),
            .prod        (tap_prod[k])
        );
    end

    // sum the products and fold in the half-LSB rounding constant
    acc_t ff_sum_reg;

    always_ff @(posedge clk)
    begin
        if (c_go)
        begin
            ff_sum_reg <= acc_t'(tap_prod[0]) + acc_t'(tap_prod[1])
                        + acc_t'(tap_prod[2]) + ROUND_HALF;
        end
    end

    // ------------------------------------------------------------------
    // Feedback loop
    // ------------------------------------------------------------------
    sample_t y;

    iir_dec_fb_loop u_fb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (d_go),
        .ff_sum  (ff_sum_reg),
        .coef_a1 (coef_a1_reg),
        .coef_a2 (coef_a2_reg),
        .y       (y)
    );

    // ------------------------------------------------------------------
    // Decimation and chunk counters
    // ------------------------------------------------------------------
    logic [DECIM_W-1:0] factor;
    logic [DECIM_W:0]   decim_inc;
    logic [POS_W-1:0]   chunk_pos_reg, chunk_pos_next;
    logic [GROUP_W-1:0] group_len;
    logic [POS_W:0]     pos_inc;
    logic               chunk_done;

    always_comb
    begin
        // a factor of zero keeps every sample
        factor    = (decim_factor_reg == '0) ? DECIM_W'(1) : decim_factor_reg;
        decim_inc = {1'b0, decim_count_reg} + (DECIM_W+1)'(1);
        if (decim_inc >= {1'b0, factor})
        begin
            decim_count_next = '0;
        end
        else
        begin
            decim_count_next = decim_inc[DECIM_W-1:0];
        end

        // clamp the group length to 1..GROUP_MAX
        if (group_length_reg == '0)
        begin
            group_len = GROUP_W'(1);
        end
        else if (group_length_reg > GROUP_W'(GROUP_MAX))
        begin
            group_len = GROUP_W'(GROUP_MAX);
        end
        else
        begin
            group_len = group_length_reg;
        end
        pos_inc    = {1'b0, chunk_pos_reg} + (POS_W+1)'(1);
        chunk_done = (pos_inc >= group_len);
        chunk_pos_next = chunk_done ? '0 : pos_inc[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_count_reg <= '0;
            chunk_pos_reg   <= '0;
        end
        else if (d_go)
        begin
            decim_count_reg <= decim_count_next;
            if (keep)
            begin
                chunk_pos_reg <= chunk_pos_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: load a kept sample, drop it after its transfer
    // ------------------------------------------------------------------
    sample_t sample_out_reg;
    logic    chunk_end_reg;

    always_comb
    begin
        if (d_go && keep)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_go && keep)
        begin
            sample_out_reg <= y;
            chunk_end_reg  <= chunk_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign chunk_end  = chunk_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a kept sample leaving the loop always lands in the output register
    a_keep_loads: assert property (@(posedge clk) disable iff (!rst_n)
        d_go && keep |=> out_valid_reg)
        else $error("kept sample did not reach the output register");

    // a stalled feedforward sum holds until the loop takes it
    a_c_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg && !d_go |=> vc_reg && $stable(ff_sum_reg))
        else $error("feedforward sum changed while waiting for the loop");

    // input is held back only when every stage is full and the output register is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> va_reg && vb_reg && vc_reg && out_valid_reg)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
